// File: rtl/core/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_DEFAULT = 256;
    localparam int EVENT_QUEUE_DEPTH   = 4;

    localparam logic [7:0] WILDCARD = 8'hFF;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BASE_ADDRESS   = 8'd0;
    localparam logic [7:0] CFG_PATTERN_LENGTH = 8'd1;

    // One scan outcome handed from the front end to the back end.
    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } t_event;

    // Write side of the event queue.
    typedef struct packed {
        logic   push;
        t_event ev;
    } t_event_push;

endpackage

`default_nettype wire

// File: rtl/core/wbps_front.sv
// Front end: pattern store, parallel partial-match bits and byte counter.
// Depends on wbps_pkg.
`default_nettype none

module wbps_front #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_accept,
    input  wire                        i_kind,
    input  wire  [7:0]                 i_pattern_index,
    input  wire  [7:0]                 i_pattern_value,
    input  wire  [7:0]                 i_data_byte,
    input  wire                        i_last_byte,
    input  wire  [63:0]                i_base_address,
    input  wire  [7:0]                 i_pattern_length,
    output wbps_pkg::t_event_push      o_push
);
    import wbps_pkg::*;

    // Only 256 entries can be addressed by an 8-bit index.
    localparam int PS = (MAX_PATTERN < 256) ? MAX_PATTERN : 256;
    localparam int IW = (PS > 1) ? $clog2(PS) : 1;

    logic [7:0]    r_store [PS];
    logic [PS-1:0] r_pm;
    logic [PS-1:0] n_pm;
    logic [31:0]   r_off;
    logic [31:0]   n_off;
    logic          r_rep;
    logic          n_rep;

    logic [PS-1:0] cand;
    logic [PS-1:0] hit_bits;
    logic [7:0]    len_m1;
    logic          scan_ok;
    logic          idx_ok;
    logic          hit;
    logic [31:0]   start;

    assign scan_ok = (i_base_address != 64'd0) && (i_pattern_length != 8'd0)
                     && (32'(i_pattern_length) < 32'(MAX_PATTERN));
    assign idx_ok  = 32'(i_pattern_index) < 32'(MAX_PATTERN);
    assign len_m1  = i_pattern_length - 8'd1;
    assign start   = r_off - 32'(len_m1);

    always_comb begin
        for (int j = 0; j < PS; j++) begin
            hit_bits[j] = (r_store[j] == WILDCARD) || (r_store[j] == i_data_byte);
        end
        cand[0] = hit_bits[0] && (i_pattern_length != 8'd0);
        for (int j = 1; j < PS; j++) begin
            cand[j] = (j < int'(i_pattern_length)) && r_pm[j-1] && hit_bits[j];
        end
    end

    assign hit = cand[len_m1[IW-1:0]];

    always_comb begin
        n_pm   = r_pm;
        n_off  = r_off;
        n_rep  = r_rep;
        o_push = '0;
        if (i_accept && (i_kind == KIND_BYTE)) begin
            if (scan_ok && !r_rep) begin
                n_pm = cand;
                if (hit) begin
                    o_push.push      = 1'b1;
                    o_push.ev.found  = 1'b1;
                    o_push.ev.offset = start;
                    n_rep            = 1'b1;
                end
            end
            if (i_last_byte) begin
                // The region closes; a not-found outcome goes out unless a match did.
                if (!n_rep) begin
                    o_push.push = 1'b1;
                    o_push.ev   = '0;
                end
                n_pm  = '0;
                n_off = 32'd0;
                n_rep = 1'b0;
            end else begin
                n_off = r_off + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm  <= '0;
            r_off <= 32'd0;
            r_rep <= 1'b0;
        end else begin
            r_pm  <= n_pm;
            r_off <= n_off;
            r_rep <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_kind == KIND_LOAD) && idx_ok) begin
            r_store[i_pattern_index[IW-1:0]] <= i_pattern_value;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wbps_queue.sv
// Short event queue that decouples the front end from the back end.
// Depends on wbps_pkg.
`default_nettype none

module wbps_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wbps_pkg::t_event_push   i_push,
    input  wire                     i_pop,
    output wbps_pkg::t_event        o_head,
    output logic                    o_valid,
    output logic                    o_full
);
    import wbps_pkg::*;

    localparam int DEPTH = EVENT_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_valid = r_count != '0;
    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.ev;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wbps_back.sv
// Back end: forms the match address and holds the result output register.
// Depends on wbps_pkg.
`default_nettype none

module wbps_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wbps_pkg::t_event    i_head,
    input  wire                 i_head_valid,
    output logic                o_head_pop,
    input  wire  [63:0]         i_base_address,
    input  wire                 i_pop,
    output logic                o_valid,
    output logic                o_found,
    output logic [63:0]         o_match_address,
    output logic [31:0]         o_match_offset
);
    import wbps_pkg::*;

    logic r_valid;

    assign o_head_pop = i_head_valid && (!r_valid || i_pop);
    assign o_valid    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_head_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            o_found         <= i_head.found;
            o_match_offset  <= i_head.offset;
            o_match_address <= i_head.found ? (i_base_address + 64'(i_head.offset))
                                            : 64'd0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner: configuration registers,
// front end, event queue and back end. Depends on wbps_pkg and the wbps_* modules.
//
// Usage. Items enter through a queue-like port: a beat is taken at a rising
// edge with push high and full low. An item either loads one pattern entry
// (kind 0; an entry of 0xFF matches any byte) or delivers one memory byte
// (kind 1, last_byte marks the end of the region). Results leave through a
// second queue-like port: the oldest result sits on the result ports while
// empty is low and is taken at an edge with pop high. Each region gives one
// result: the first full match (found, offset and base plus offset), or a
// not-found result on its final byte. base_address and pattern_length are set
// through the configuration channel, which is always ready; the user must set
// them only while the block is idle, which the block itself does not enforce.
// Throughput is one item per cycle while full is low; that figure is set by the
// partial-match register, whose new value depends on the previous one and is
// computed combinationally for every pattern position in parallel. A result
// reaches the result ports by way of the event queue: the outcome enters the
// event queue at the accepting edge and moves into the output register once
// that register is empty or being popped.
// Reset is synchronous; no clearing pass follows. When the receiver stalls,
// results wait in a four-entry queue behind the output register and full
// rises only once that queue fills.
`default_nettype none

module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Item channel.
    input  wire         push,
    output logic        full,
    input  wire         i_kind,
    input  wire  [7:0]  i_pattern_index,
    input  wire  [7:0]  i_pattern_value,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    // Result channel.
    output logic        empty,
    input  wire         pop,
    output logic        o_found,
    output logic [63:0] o_match_address,
    output logic [31:0] o_match_offset,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);
    import wbps_pkg::*;

    logic [63:0] r_base_address;
    logic [7:0]  r_pattern_length;

    logic        in_accept;
    t_event_push ev_push;
    t_event      q_head;
    logic        q_valid;
    logic        q_pop;
    logic        res_valid;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;
    assign empty       = !res_valid;

    // Configuration registers; a beat to an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address   <= 64'd0;
            r_pattern_length <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDRESS:   r_base_address   <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    wbps_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_kind          (i_kind),
        .i_pattern_index (i_pattern_index),
        .i_pattern_value (i_pattern_value),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_base_address  (r_base_address),
        .i_pattern_length(r_pattern_length),
        .o_push          (ev_push)
    );

    // The queue's full flag throttles the item channel, so no outcome is lost.
    wbps_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (ev_push),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_valid(q_valid),
        .o_full (full)
    );

    wbps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_head_valid   (q_valid),
        .o_head_pop     (q_pop),
        .i_base_address (r_base_address),
        .i_pop          (pop),
        .o_valid        (res_valid),
        .o_found        (o_found),
        .o_match_address(o_match_address),
        .o_match_offset (o_match_offset)
    );

    // A found result carries base plus offset, as the user, not the block, changes base only when idle.
    a_found_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> (o_match_address == r_base_address + 64'(o_match_offset)))
        else $error("found result address does not equal base plus offset");

    // A not-found result carries zero address and offset.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_match_address == 64'd0 && o_match_offset == 32'd0))
        else $error("not-found result carries nonzero address or offset");

    // The cycle after reset, nothing is pending and items are taken.
    a_reset_state: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("block not empty and ready after reset");

endmodule

`default_nettype wire

// File: verif/tb_wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_scan: a directed table, then random
// pattern loads and byte regions, checked against an in-bench scan model or the table.
// Depends on wbps_pkg and the RTL of the scanner.

module tb_wildcard_byte_pattern_scan;
    import wbps_pkg::*;

    // One result as the block presents it on its result ports.
    typedef struct packed {
        logic        found;
        logic [63:0] address;
        logic [31:0] offset;
    } t_scan_result;

    // One input beat. When typed is set, typed_res is the result written into the
    // directed table by hand and it takes the place of the predicted one.
    typedef struct packed {
        logic         kind;
        logic [7:0]   index;
        logic [7:0]   value;
        logic [7:0]   data;
        logic         last;
        logic         typed;
        t_scan_result typed_res;
    } t_scan_item;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_scan_item item;
        logic [7:0] cfg_index;
        logic [63:0] cfg_data;
    } t_stim_row;

    localparam int PHASES          = 18;
    localparam int ITEMS_PER_PHASE = 80;
    // The phase in which the receiver stops popping for a long stretch.
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 300;
    // The only phase that uses the longest pattern the length register allows.
    localparam int LONG_PHASE      = 13;
    localparam int TIMEOUT_NS      = 3_000_000;

    // Every input of the block starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_kind = KIND_LOAD;
    logic [7:0]  i_pattern_index = '0;
    logic [7:0]  i_pattern_value = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_found;
    logic [63:0] o_match_address;
    logic [31:0] o_match_offset;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    wildcard_byte_pattern_scan dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_pattern_index (i_pattern_index),
        .i_pattern_value (i_pattern_value),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_found         (o_found),
        .o_match_address (o_match_address),
        .o_match_offset  (o_match_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Scan model state, kept apart from the RTL. The pattern store has no reset
    // value; the stimulus never lets a scan compare against an entry not yet loaded.
    logic [7:0]   model_pattern [256];
    logic [255:0] model_partial = '0;
    logic [31:0]  model_offset = '0;
    logic         model_reported = 1'b0;
    logic [63:0]  model_base = '0;
    logic [7:0]   model_length = '0;

    t_scan_result pending_results[$];
    t_scan_item   send_queue[$];
    t_scan_item   on_port = '0;
    t_stim_row    directed[$];
    logic [7:0]   gen_pattern [256];

    int mismatch_count = 0;
    int phase_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic entry_hit(input int j, input logic [7:0] b);
        return model_pattern[j] == WILDCARD || model_pattern[j] == b;
    endfunction

    // Advances the scan model by one accepted beat. Returns 1 when the beat
    // produces a result, which is then left in res.
    function automatic logic scan_predict(input t_scan_item it, output t_scan_result res);
        int          len;
        logic        scan_on;
        logic [31:0] start;
        logic        produced;
        res = '0;
        produced = 1'b0;
        if (it.kind == KIND_LOAD) begin
            model_pattern[it.index] = it.value;
            return 1'b0;
        end
        len = model_length;
        scan_on = model_base != 0 && len != 0;
        if (scan_on && !model_reported) begin
            // Bits at or above the current length are dropped, so a length that
            // shrank in the middle of a region takes effect at once.
            for (int j = 255; j >= len; j--) begin
                model_partial[j] = 1'b0;
            end
            // Walk downward so that every position still sees the old bit below it.
            for (int j = len - 1; j > 0; j--) begin
                model_partial[j] = model_partial[j - 1] && entry_hit(j, it.data);
            end
            model_partial[0] = entry_hit(0, it.data);
            if (model_partial[len - 1]) begin
                start = model_offset - 32'(len - 1);
                res.found = 1'b1;
                res.address = model_base + {32'd0, start};
                res.offset = start;
                model_reported = 1'b1;
                produced = 1'b1;
            end
        end
        if (it.last) begin
            // A region that closes without a match reports not found; one that
            // already matched closes silently.
            if (!model_reported) begin
                res = '0;
                produced = 1'b1;
            end
            model_partial = '0;
            model_offset = '0;
            model_reported = 1'b0;
        end else begin
            model_offset = model_offset + 32'd1;
        end
        return produced;
    endfunction

    // Input side. At each edge the beat on the port is either taken (push high,
    // full low) and run through the scan model, or held while full is high.
    // A fresh beat is offered only once the previous one has gone.
    always @(posedge i_clk) begin
        t_scan_result predicted;
        t_scan_item   upcoming;
        logic         has_res;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                has_res = scan_predict(on_port, predicted);
                if (on_port.typed) begin
                    pending_results.push_back(on_port.typed_res);
                end else if (has_res) begin
                    pending_results.push_back(predicted);
                end
            end
            if (!push || !full) begin
                if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    upcoming = send_queue.pop_front();
                    on_port <= upcoming;
                    i_kind <= upcoming.kind;
                    i_pattern_index <= upcoming.index;
                    i_pattern_value <= upcoming.value;
                    i_data_byte <= upcoming.data;
                    i_last_byte <= upcoming.last;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side. Each beat taken is compared field by field with the oldest
    // expectation. A hold-off request from the stimulus stops popping for a long
    // stretch, counted here, so that the block's result queue fills and full rises.
    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, address", o_match_address, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch("found", o_found, want.found);
                    end
                    if (o_match_address !== want.address) begin
                        report_mismatch("match_address", o_match_address, want.address);
                    end
                    if (o_match_offset !== want.offset) begin
                        report_mismatch("match_offset", o_match_offset, want.offset);
                    end
                end
            end
            if (holds_done != holds_asked) begin
                holds_done <= holds_asked;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    function automatic t_scan_item load_item(input logic [7:0] index, input logic [7:0] value);
        t_scan_item it;
        it = '0;
        it.kind = KIND_LOAD;
        it.index = index;
        it.value = value;
        // The byte fields mean nothing on a load, so they carry noise.
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    function automatic t_scan_item byte_item(input logic [7:0] data, input logic last);
        t_scan_item it;
        it = '0;
        it.kind = KIND_BYTE;
        it.index = 8'($urandom);
        it.value = 8'($urandom);
        it.data = data;
        it.last = last;
        return it;
    endfunction

    task automatic row_item(input t_scan_item it);
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = it;
        directed.push_back(row);
    endtask

    task automatic row_typed(input logic [7:0] data, input logic last, input logic found,
                             input logic [63:0] address, input logic [31:0] offset);
        t_scan_item it;
        it = byte_item(data, last);
        it.typed = 1'b1;
        it.typed_res.found = found;
        it.typed_res.address = address;
        it.typed_res.offset = offset;
        row_item(it);
    endtask

    task automatic row_cfg(input logic [7:0] index, input logic [63:0] value);
        t_stim_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg_index = index;
        row.cfg_data = value;
        directed.push_back(row);
    endtask

    task automatic queue_item(input t_scan_item it);
        while (send_queue.size() > 8) begin
            @(negedge i_clk);
        end
        send_queue.push_back(it);
        phase_items++;
    endtask

    // The block counts as idle once every beat has gone in and every expected result
    // has come out; the task then waits on for a load or a silent byte that may still
    // be in the pipeline.
    task automatic wait_for_idle();
        @(negedge i_clk);
        while (send_queue.size() != 0 || push || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [63:0] value);
        wait_for_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == CFG_BASE_ADDRESS) begin
            model_base = value;
        end else if (index == CFG_PATTERN_LENGTH) begin
            model_length = value[7:0];
        end
        @(negedge i_clk);
    endtask

    // One random phase under the current settings. With a usable base and length
    // it loads a full pattern, then streams regions: mostly the pattern embedded in
    // random bytes, some with the pattern broken or cut short, and some plain noise
    // with stray loads in the middle of a scan.
    task automatic run_phase(input int len, input logic scan_on);
        int         cut;
        int         bad;
        int         pick;
        int         n;
        logic [7:0] v;
        logic [7:0] b;
        logic [7:0] region[$];
        if (scan_on) begin
            for (int i = 0; i < len; i++) begin
                v = ($urandom_range(4) == 0) ? WILDCARD : 8'($urandom);
                gen_pattern[i] = v;
                queue_item(load_item(8'(i), v));
            end
        end
        // The stream after the pattern load gets its own share, even for a long pattern.
        phase_items = 0;
        while (phase_items < ITEMS_PER_PHASE) begin
            pick = $urandom_range(9);
            if (!scan_on || pick >= 8) begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(7) == 0) begin
                        b = 8'($urandom);
                        v = 8'($urandom);
                        gen_pattern[b] = v;
                        queue_item(load_item(b, v));
                    end else begin
                        queue_item(byte_item(8'($urandom),
                                             k == n - 1 && $urandom_range(3) != 0));
                    end
                end
            end else begin
                region.delete();
                cut = len;
                bad = -1;
                if (pick >= 6) begin
                    if ($urandom_range(1) != 0) begin
                        cut = $urandom_range(len - 1);
                    end else begin
                        bad = $urandom_range(len - 1);
                    end
                end
                // Leading bytes are often taken from the pattern itself, so that
                // false starts overlap the real match.
                repeat ($urandom_range(5)) begin
                    region.push_back(($urandom_range(1) != 0) ?
                                     gen_pattern[$urandom_range(len - 1)] : 8'($urandom));
                end
                for (int i = 0; i < cut; i++) begin
                    b = (gen_pattern[i] == WILDCARD) ? 8'($urandom) : gen_pattern[i];
                    if (i == bad) begin
                        b = b ^ (8'h01 << $urandom_range(7));
                    end
                    region.push_back(b);
                end
                repeat ($urandom_range(4)) begin
                    region.push_back(8'($urandom));
                end
                if (region.size() == 0) begin
                    region.push_back(8'($urandom));
                end
                foreach (region[k]) begin
                    queue_item(byte_item(region[k], k == region.size() - 1));
                end
            end
        end
    endtask

    initial begin
        int          len;
        int          pick;
        logic [63:0] base;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. Straight out of reset the base and the length are zero,
        // so a region's final byte reports not found.
        row_typed(8'h00, 1'b1, 1'b0, 64'd0, 32'd0);
        row_cfg(CFG_PATTERN_LENGTH, 64'd3);
        // A zero base still means not found, whatever the bytes.
        row_typed(8'hFF, 1'b1, 1'b0, 64'd0, 32'd0);
        row_cfg(CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
        // Pattern 12, wildcard, 34; entry 3 is loaded for the longer runs below.
        row_item(load_item(8'd0, 8'h12));
        row_item(load_item(8'd1, WILDCARD));
        row_item(load_item(8'd2, 8'h34));
        row_item(load_item(8'd3, 8'h00));
        // A match at offset zero reports the base itself, the largest address.
        row_item(byte_item(8'h12, 1'b0));
        row_item(byte_item(8'h77, 1'b0));
        row_typed(8'h34, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        // After a match the region closes silently on its final byte.
        row_item(byte_item(8'h00, 1'b1));
        // A match on the final byte at offset one; the address wraps to zero.
        // A literal 0xFF byte meets the wildcard entry.
        row_item(byte_item(8'h00, 1'b0));
        row_item(byte_item(8'h12, 1'b0));
        row_item(byte_item(8'hFF, 1'b0));
        row_typed(8'h34, 1'b1, 1'b1, 64'd0, 32'd1);
        // A near miss in the last entry: not found.
        row_item(byte_item(8'h12, 1'b0));
        row_item(byte_item(8'h34, 1'b0));
        row_typed(8'h35, 1'b1, 1'b0, 64'd0, 32'd0);
        // The length shrinks in the middle of a region.
        row_item(byte_item(8'h12, 1'b0));
        row_item(byte_item(8'h55, 1'b0));
        row_cfg(CFG_PATTERN_LENGTH, 64'd2);
        row_item(byte_item(8'h12, 1'b0));
        row_item(byte_item(8'h99, 1'b0));
        row_item(byte_item(8'h00, 1'b1));
        // A load in the middle of a scan changes the entry for the bytes after it.
        row_cfg(CFG_PATTERN_LENGTH, 64'd4);
        row_item(load_item(8'd3, WILDCARD));
        row_item(byte_item(8'h12, 1'b0));
        row_item(load_item(8'd2, 8'h56));
        row_item(byte_item(8'h44, 1'b0));
        row_item(byte_item(8'h56, 1'b0));
        row_item(byte_item(8'h01, 1'b1));
        // Bytes under a zero base are counted but never compared.
        row_cfg(CFG_BASE_ADDRESS, 64'd0);
        row_item(byte_item(8'h12, 1'b0));
        row_typed(8'h34, 1'b1, 1'b0, 64'd0, 32'd0);

        send_idle_pct = 21;
        recv_idle_pct = 57;
        foreach (directed[n]) begin
            if (directed[n].kind == ROW_CFG) begin
                write_register(directed[n].cfg_index, directed[n].cfg_data);
            end else begin
                queue_item(directed[n].item);
            end
        end

        // Random phases. The first third idles the sender lightly and the receiver
        // heavily, the second third the other way round, the last not at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_idle();
            case (phase * 3 / PHASES)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            pick = $urandom_range(9);
            if (phase == 11) begin
                base = 64'd0;
            end else if (phase == 7 || pick == 0) begin
                base = 64'hFFFF_FFFF_FFFF_FFFF;
            end else if (pick < 3) begin
                base = 64'($urandom_range(1, 255));
            end else begin
                base = {$urandom, $urandom};
                if (base == 64'd0) begin
                    base = 64'd1;
                end
            end
            pick = $urandom_range(9);
            if (phase == HOLD_PHASE) begin
                len = 1;
            end else if (phase == LONG_PHASE) begin
                len = 255;
            end else if (phase == 9) begin
                len = 0;
            end else if (pick == 0) begin
                len = $urandom_range(20, 60);
            end else begin
                len = $urandom_range(1, 6);
            end
            write_register(CFG_BASE_ADDRESS, base);
            write_register(CFG_PATTERN_LENGTH, 64'(len));
            if (phase == HOLD_PHASE) begin
                holds_asked++;
            end
            run_phase(len, base != 64'd0 && len != 0);
        end

        while (send_queue.size() != 0 || push) begin
            @(negedge i_clk);
        end
        for (int k = 0; k < 20000 && pending_results.size() != 0; k++) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered, count", '0, pending_results.size());
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
